/* sv/sync_length_checksum_deframer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length/checksum deframer
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication: whenever the condition holds, so must the check.
`define SLCD_ASSERT_IMP(lbl, cond, chk) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (chk)) \
        else $error("slcd: same-cycle check failed");

// Next-cycle implication: the check must hold in the cycle after the condition.
`define SLCD_ASSERT_NXT(lbl, cond, chk) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (chk)) \
        else $error("slcd: next-cycle check failed");

`endif

/* sv/slcd_pkg.sv */
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants for the sync/length/checksum byte deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

    // Byte that marks frame sync; three in a row open a frame.
    localparam logic [7:0] SYNC_BYTE = 8'h80;

    // Number of consecutive sync bytes needed, less one (count runs 0..2).
    localparam logic [1:0] SYNC_LAST = 2'd2;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    // Frame receive phases, one-hot.
    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_LENGTH  = 7'b0000010,
        PH_DEVICE  = 7'b0000100,
        PH_NUMBER  = 7'b0001000,
        PH_COMMAND = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CHECK   = 7'b1000000
    } t_phase;

    // One result transaction.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] device;
        logic [7:0] unit_number;
        logic [7:0] command;
        logic [7:0] frame_length;
        logic [7:0] byte_index;
        logic [7:0] data_byte;
    } t_result;

endpackage

`default_nettype wire

/* sv/sync_length_checksum_deframer.sv */
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Hunts for a three-byte sync, parses a length/device/number/command header,
// forwards payload bytes and reports the additive checksum verdict or a too-long length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_rx_valid / o_rx_stall carry one received byte per
//   transaction on i_rx_byte. Output channel: o_res_valid / i_res_stall carry
//   one result per transaction (payload byte, frame end good, frame end bad
//   checksum, or length too long).
//   Each byte is processed in the cycle it is accepted; any result it causes
//   is registered in the result buffer before the outputs. Throughput is one
//   byte per clock while o_rx_stall is low, set by the single state update
//   between input and result register. A two-entry result buffer (output
//   register plus skid register) lets the block keep accepting bytes while
//   one result waits; o_rx_stall rises only when both entries are full, so a
//   stalled receiver backs up the input after at most two pending results.
//   The max_payload register is written through i_cfg_we / i_cfg_wdata and is
//   sampled only when a length byte arrives.
//   Synchronous reset (i_rst_n low) returns to sync hunting, empties the
//   result buffer and sets max_payload to 255.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_length_checksum_deframer_defines.svh"

module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    // Received bytes
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    // Results
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_device,
    output logic [7:0]      o_unit_number,
    output logic [7:0]      o_command,
    output logic [7:0]      o_frame_length,
    output logic [7:0]      o_byte_index,
    output logic [7:0]      o_data_byte
);

    // Frame state.
    t_phase     r_phase,  n_phase;
    logic [1:0] r_sync,   n_sync;
    logic [7:0] r_len,    n_len;
    logic [7:0] r_dev,    n_dev;
    logic [7:0] r_num,    n_num;
    logic [7:0] r_cmd,    n_cmd;
    logic [7:0] r_pcount, n_pcount;
    logic [7:0] r_sum,    n_sum;
    logic [7:0] r_max_payload;

    // Result buffer.
    t_result r_head, r_skid, res;
    logic    r_head_valid, r_skid_valid;
    logic    res_valid;

    logic in_acc, out_take;

    assign o_rx_stall = r_skid_valid;
    assign in_acc     = i_rx_valid && !o_rx_stall;
    assign out_take   = r_head_valid && !i_res_stall;

    // Per-byte state update and result formation.
    always_comb begin
        n_phase   = r_phase;
        n_sync    = r_sync;
        n_len     = r_len;
        n_dev     = r_dev;
        n_num     = r_num;
        n_cmd     = r_cmd;
        n_pcount  = r_pcount;
        n_sum     = r_sum;
        res_valid = 1'b0;
        res       = '{kind: KIND_PAYLOAD, device: r_dev, unit_number: r_num,
                      command: r_cmd, frame_length: r_len, byte_index: 8'd0,
                      data_byte: 8'd0};
        case (r_phase)
            PH_LENGTH: begin
                n_len = i_rx_byte;
                n_sum = i_rx_byte;
                if (i_rx_byte > r_max_payload) begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_TOO_LONG;
                    res.device       = 8'd0;
                    res.unit_number  = 8'd0;
                    res.command      = 8'd0;
                    res.frame_length = i_rx_byte;
                    n_phase          = PH_HUNT;
                    n_sync           = 2'd0;
                end else begin
                    n_phase = PH_DEVICE;
                end
            end
            PH_DEVICE: begin
                n_dev   = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_phase = PH_NUMBER;
            end
            PH_NUMBER: begin
                n_num   = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_phase = PH_COMMAND;
            end
            PH_COMMAND: begin
                n_cmd    = i_rx_byte;
                n_sum    = r_sum + i_rx_byte;
                n_pcount = 8'd0;
                n_phase  = (r_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                res_valid      = 1'b1;
                res.kind       = KIND_PAYLOAD;
                res.byte_index = r_pcount;
                res.data_byte  = i_rx_byte;
                n_sum          = r_sum + i_rx_byte;
                n_pcount       = r_pcount + 8'd1;
                if (n_pcount == r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                res_valid = 1'b1;
                res.kind  = (i_rx_byte == r_sum) ? KIND_GOOD : KIND_BAD;
                n_phase   = PH_HUNT;
                n_sync    = 2'd0;
            end
            default: begin
                // Sync hunting; an unknown phase code also lands here.
                n_phase = PH_HUNT;
                if (i_rx_byte == SYNC_BYTE) begin
                    if (r_sync == SYNC_LAST) begin
                        n_sync  = 2'd0;
                        n_phase = PH_LENGTH;
                    end else begin
                        n_sync = r_sync + 2'd1;
                    end
                end else begin
                    n_sync = 2'd0;
                end
            end
        endcase
    end

    // State registers advance on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_sync   <= 2'd0;
            r_len    <= 8'd0;
            r_dev    <= 8'd0;
            r_num    <= 8'd0;
            r_cmd    <= 8'd0;
            r_pcount <= 8'd0;
            r_sum    <= 8'd0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_sync   <= n_sync;
            r_len    <= n_len;
            r_dev    <= n_dev;
            r_num    <= n_num;
            r_cmd    <= n_cmd;
            r_pcount <= n_pcount;
            r_sum    <= n_sum;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= 8'hFF;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

    // Result buffer control: the skid entry fills only while the head is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_head_valid || out_take) begin
            r_head_valid <= r_skid_valid || (in_acc && res_valid);
            r_skid_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result buffer data.
    always_ff @(posedge i_clk) begin
        if (!r_head_valid || out_take) begin
            r_head <= r_skid_valid ? r_skid : res;
        end else if (in_acc && res_valid) begin
            r_skid <= res;
        end
    end

    // Output ports.
    assign o_res_valid    = r_head_valid;
    assign o_kind         = r_head.kind;
    assign o_device       = r_head.device;
    assign o_unit_number  = r_head.unit_number;
    assign o_command      = r_head.command;
    assign o_frame_length = r_head.frame_length;
    assign o_byte_index   = r_head.byte_index;
    assign o_data_byte    = r_head.data_byte;

    // Checks on the buffer ordering, payload indexing and frame sequencing.
    `SLCD_ASSERT_IMP(a_skid_behind_head, r_skid_valid, r_head_valid)
    `SLCD_ASSERT_IMP(a_index_in_frame, o_res_valid && (o_kind == KIND_PAYLOAD),
                     o_byte_index < o_frame_length)
    `SLCD_ASSERT_IMP(a_hunt_silent, in_acc && (r_phase == PH_HUNT), !res_valid)
    `SLCD_ASSERT_NXT(a_check_ends_frame, in_acc && (r_phase == PH_CHECK),
                     (r_phase == PH_HUNT) && (r_sync == 2'd0))

endmodule

`default_nettype wire
